// ----- rtl/core/tldim_pkg.sv -----
// Package for the two-lamp dimmer: lamp level codes, register map, reset values
// and the small per-lamp helper functions.
// No dependencies; used by two_lamp_dimmer_with_auto_off_top.
`default_nettype none

package tldim_pkg;

    // Lamp levels
    typedef logic [1:0] t_level;
    localparam t_level LVL_OFF  = 2'd0;
    localparam t_level LVL_LOW  = 2'd1;
    localparam t_level LVL_HIGH = 2'd2;

    // Item kinds carried in tuser
    localparam logic ACT_SLOW    = 1'b0;
    localparam logic ACT_REFRESH = 1'b1;

    // Register map (word index = paddr[3:2])
    localparam int ADDR_W = 4;
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_AUTO_OFF = 2'd0;
    localparam t_reg_idx REG_BLINK    = 2'd1;
    localparam t_reg_idx REG_DUTY     = 2'd2;

    // Register reset values
    localparam logic [15:0] AUTO_OFF_RST = 16'd12000;
    localparam logic [7:0]  BLINK_RST    = 8'd25;
    localparam logic [7:0]  DUTY_RST     = 8'd10;

    // Blink sequence length: two on/off blinks
    localparam logic [1:0] BLINK_COUNT = 2'd2;

    // off -> low -> high -> off
    function automatic t_level step_level(input t_level lv);
        step_level = (lv >= LVL_HIGH) ? LVL_OFF : t_level'(lv + 2'd1);
    endfunction

    // Pin level for a lamp at the given refresh phase
    function automatic logic pin_for(input t_level lv, input logic phase_zero);
        if (lv == LVL_OFF) begin
            pin_for = 1'b0;
        end else if (lv == LVL_LOW) begin
            pin_for = phase_zero;
        end else begin
            pin_for = 1'b1;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/two_lamp_dimmer_with_auto_off_top.sv -----
// Two-lamp dimmer with auto-off, indicator blink and sleep request.
// Depends on tldim_pkg (level codes, register map, helper functions).
`default_nettype none

// Each accepted item is a tick: tuser 0 is a slow control tick carrying the two
// press events in tdata, tuser 1 a fast refresh tick. Every item yields exactly
// one result, the lamp pins, levels, indicator and sleep request after the
// tick, in the output register. The block takes one item per cycle: all state
// updates are a single pass of counter decrements and compares, and input ready
// only drops while the output register holds a result the downstream side has
// not taken. Registers are to be written over APB only while the stream is
// idle (not enforced by the block); reads return the current register values.
module two_lamp_dimmer_with_auto_off_top
    import tldim_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    // input items
    input  wire               i_s_tvalid,
    output logic              o_s_tready,
    input  wire  [7:0]        i_s_tdata,   // [0] press_one, [1] press_two, [7:2] zero
    input  wire               i_s_tuser,   // [0] action
    // result items
    output logic              o_m_tvalid,
    input  wire               i_m_tready,
    output logic [7:0]        o_m_tdata,   // [0] drive_one, [1] drive_two,
                                           // [3:2] level_one, [5:4] level_two,
                                           // [6] indicator, [7] sleep_request
    // configuration
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [ADDR_W-1:0] paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Configuration registers
    logic [15:0] r_auto_off;
    logic [7:0]  r_blink_half;
    logic [7:0]  r_duty;

    // Block state
    t_level      r_lvl1, r_lvl2;
    logic [15:0] r_off_cnt;
    logic        r_ind;
    logic [1:0]  r_blinks;
    logic [7:0]  r_blink_cnt;
    logic [7:0]  r_phase;
    logic        r_pin1, r_pin2;

    // Output register
    logic        r_out_valid;
    logic [7:0]  r_out_data;

    // Next-state values
    t_level      n_lvl1, n_lvl2;
    logic [15:0] n_off_cnt;
    logic        n_ind;
    logic [1:0]  n_blinks;
    logic [7:0]  n_blink_cnt;
    logic [7:0]  n_phase;
    logic        n_pin1, n_pin2;
    logic        n_sleep;

    logic        s_accept;
    logic        p1, p2, pressed;
    logic [15:0] off_dec;
    logic [7:0]  blink_dec;
    logic [8:0]  phase_inc;
    t_reg_idx    reg_idx;
    logic        cfg_wr;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign p1         = i_s_tdata[0];
    assign p2         = i_s_tdata[1];
    assign pressed    = p1 || p2;

    // APB decode
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_AUTO_OFF: prdata = {16'd0, r_auto_off};
            REG_BLINK:    prdata = {24'd0, r_blink_half};
            REG_DUTY:     prdata = {24'd0, r_duty};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_off   <= AUTO_OFF_RST;
            r_blink_half <= BLINK_RST;
            r_duty       <= DUTY_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_AUTO_OFF: r_auto_off   <= pwdata[15:0];
                REG_BLINK:    r_blink_half <= pwdata[7:0];
                REG_DUTY:     r_duty       <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    // Tick processing
    always_comb begin
        n_lvl1      = r_lvl1;
        n_lvl2      = r_lvl2;
        n_off_cnt   = r_off_cnt;
        n_ind       = r_ind;
        n_blinks    = r_blinks;
        n_blink_cnt = r_blink_cnt;
        n_phase     = r_phase;
        n_pin1      = r_pin1;
        n_pin2      = r_pin2;
        off_dec     = (r_off_cnt != 16'd0) ? r_off_cnt - 16'd1 : 16'd0;
        blink_dec   = (r_blink_cnt != 8'd0) ? r_blink_cnt - 8'd1 : 8'd0;
        phase_inc   = {1'b0, r_phase} + 9'd1;

        if (i_s_tuser == ACT_REFRESH) begin
            // phase wraps at the duty period; a zero period keeps it at zero
            n_phase = (phase_inc >= {1'b0, r_duty}) ? 8'd0 : phase_inc[7:0];
            n_pin1  = pin_for(r_lvl1, n_phase == 8'd0);
            n_pin2  = pin_for(r_lvl2, n_phase == 8'd0);
        end else begin
            // auto-off expiry comes before the presses
            n_off_cnt   = off_dec;
            n_blink_cnt = blink_dec;
            if (off_dec == 16'd0) begin
                n_lvl1 = LVL_OFF;
                n_lvl2 = LVL_OFF;
            end
            if (p1) n_lvl1 = step_level(n_lvl1);
            if (p2) n_lvl2 = step_level(n_lvl2);
            if (pressed && (n_lvl1 != LVL_OFF || n_lvl2 != LVL_OFF)) begin
                n_off_cnt = r_auto_off;
            end
            // a press restarts the blink sequence
            if (pressed) begin
                n_blinks    = BLINK_COUNT;
                n_blink_cnt = 8'd0;
            end
            if (n_blinks != 2'd0 && n_blink_cnt == 8'd0) begin
                if (r_ind) begin
                    n_ind    = 1'b0;
                    n_blinks = n_blinks - 2'd1;
                end else begin
                    n_ind = 1'b1;
                end
                if (n_blinks != 2'd0) n_blink_cnt = r_blink_half;
            end
        end
        n_sleep = (n_lvl1 == LVL_OFF) && (n_lvl2 == LVL_OFF) && (n_blinks == 2'd0);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl1      <= LVL_OFF;
            r_lvl2      <= LVL_OFF;
            r_off_cnt   <= 16'd0;
            r_ind       <= 1'b0;
            r_blinks    <= 2'd0;
            r_blink_cnt <= 8'd0;
            r_phase     <= 8'd0;
            r_pin1      <= 1'b0;
            r_pin2      <= 1'b0;
        end else if (s_accept) begin
            r_lvl1      <= n_lvl1;
            r_lvl2      <= n_lvl2;
            r_off_cnt   <= n_off_cnt;
            r_ind       <= n_ind;
            r_blinks    <= n_blinks;
            r_blink_cnt <= n_blink_cnt;
            r_phase     <= n_phase;
            r_pin1      <= n_pin1;
            r_pin2      <= n_pin2;
        end
    end

    // Output register: valid flag under reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= s_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_data <= {n_sleep, n_ind, n_lvl2, n_lvl1, n_pin2, n_pin1};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks
    a_level_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl1 != 2'd3 && r_lvl2 != 2'd3)
        else $error("lamp level reached an unused code");

    a_press_arms_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && i_s_tuser == ACT_SLOW && (i_s_tdata[0] || i_s_tdata[1])
        |=> r_blinks != 2'd0)
        else $error("press did not start a blink sequence");

    a_refresh_keeps_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && i_s_tuser == ACT_REFRESH
        |=> $stable(r_lvl1) && $stable(r_lvl2) && $stable(r_off_cnt) && $stable(r_ind))
        else $error("refresh tick changed control state");

endmodule

`default_nettype wire
